// ===== rtl/newton_square_root_macros.svh =====
// Assertion macros shared by the square root checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH

// same-cycle implication
`define NSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// delayed implication (|=> followed by ##1)
`define NSR_ASSERT_DLY2(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error(msg);

`endif

// ===== rtl/nsr_pkg.sv =====
// Types and constants for the Newton-Raphson square root block.
// No dependencies; used by the control, divider and top level.
package nsr_pkg;

   localparam int DATA_W    = 32;
   localparam int ROOT_W    = 28;
   localparam int TOL_W     = 25;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [TOL_W-1:0]  TOL_RESET = 25'd6;
   localparam logic [ROOT_W-1:0] ROOT_MAX  = 28'hFFF_FFFF;

   typedef enum logic [2:0] {
      NSR_IDLE,
      NSR_START,
      NSR_WAIT,
      NSR_CHECK,
      NSR_FINISH
   } nsr_state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] rem_init;
      logic [DATA_W-1:0] low_init;
      logic [DATA_W-1:0] divisor;
   } nsr_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } nsr_div_rsp_type;

endpackage

// ===== rtl/nsr_if.sv =====
// Valid/ready channel interfaces for the square root block.
// No dependencies; used by the top level ports.
interface nsr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] radicand;
   modport source (output valid, radicand, input ready);
   modport sink   (input valid, radicand, output ready);
endinterface

interface nsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] root;
   logic        hit_limit;
   modport source (output valid, root, hit_limit, input ready);
   modport sink   (input valid, root, hit_limit, output ready);
endinterface

interface nsr_csr_if;
   logic        valid;
   logic        ready;
   logic [24:0] tolerance;
   modport source (output valid, tolerance, input ready);
   modport sink   (input valid, tolerance, output ready);
endinterface

// ===== rtl/newton_square_root.sv =====
// Q8.24 square root by Newton-Raphson; one item at a time.
// Each Newton step (at most MAX_ITER) starts the shared divider and waits for its done,
// then runs the stop test; a zero radicand skips the divider and goes straight to the result.
// Next item accepted on return to idle.
// Reset: synchronous, clears control and sets tolerance to 6.
// Depends on nsr_pkg, nsr_if, nsr_divider and nsr_newton_ctrl.
module newton_square_root #(
   parameter int MAX_ITER  = 32,
   parameter int FRAC_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   nsr_req_if.sink    req_ch,
   nsr_rsp_if.source  rsp_ch,
   nsr_csr_if.sink    csr_ch
);

   logic [nsr_pkg::TOL_W-1:0] tol_ff;
   nsr_pkg::nsr_div_req_type  div_req;
   nsr_pkg::nsr_div_rsp_type  div_rsp;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= nsr_pkg::TOL_RESET;
      end else if (csr_ch.valid) begin
         tol_ff <= csr_ch.tolerance;
      end
   end

   nsr_newton_ctrl #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .tolerance     (tol_ff),
      .req_valid     (req_ch.valid),
      .req_radicand  (req_ch.radicand),
      .req_ready     (req_ch.ready),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_root      (rsp_ch.root),
      .rsp_hit_limit (rsp_ch.hit_limit),
      .div_req       (div_req),
      .div_rsp       (div_rsp)
   );

   nsr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// ===== rtl/nsr_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on nsr_pkg; shared by every Newton step of nsr_newton_ctrl.
module nsr_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  nsr_pkg::nsr_div_req_type div_req,
   output nsr_pkg::nsr_div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [nsr_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [nsr_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [nsr_pkg::DATA_W-1:0]    quo_ff, quo_in;
   logic [nsr_pkg::DATA_W-1:0]    div_ff, div_in;
   logic [nsr_pkg::DATA_W:0]      shifted_w;
   logic [nsr_pkg::DATA_W:0]      diff_w;
   logic                          fits_w;

   assign shifted_w = {rem_ff, quo_ff[nsr_pkg::DATA_W-1]};
   assign diff_w    = shifted_w - {1'b0, div_ff};
   assign fits_w    = shifted_w >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = div_req.rem_init;
         quo_in   = div_req.low_init;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits_w ? diff_w[nsr_pkg::DATA_W-1:0]
                           : shifted_w[nsr_pkg::DATA_W-1:0];
         quo_in   = {quo_ff[nsr_pkg::DATA_W-2:0], fits_w};
         count_in = count_ff + 1'b1;
         if (count_ff == nsr_pkg::DIV_CNT_W'(nsr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/nsr_newton_ctrl.sv =====
// Newton step sequencer: guess register, step count, stop test, result register.
// Depends on nsr_pkg; drives nsr_divider through the request struct.
module nsr_newton_ctrl #(
   parameter int MAX_ITER  = 32,
   parameter int FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [nsr_pkg::TOL_W-1:0] tolerance,
   input  logic                     req_valid,
   input  logic [nsr_pkg::DATA_W-1:0] req_radicand,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [nsr_pkg::ROOT_W-1:0] rsp_root,
   output logic                     rsp_hit_limit,
   output nsr_pkg::nsr_div_req_type  div_req,
   input  nsr_pkg::nsr_div_rsp_type  div_rsp
);

   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam logic [nsr_pkg::DATA_W-1:0] GUESS_ONE = nsr_pkg::DATA_W'(1) << FRAC_BITS;

   nsr_pkg::nsr_state_type        state_ff, state_in;
   logic [nsr_pkg::DATA_W-1:0]    rad_ff, rad_in;
   logic [nsr_pkg::DATA_W-1:0]    guess_ff, guess_in;
   logic [nsr_pkg::DATA_W-1:0]    next_ff, next_in;
   logic [ITER_W-1:0]             iter_ff, iter_in;
   logic                          limit_ff, limit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [nsr_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic                          hit_ff, hit_in;

   logic [nsr_pkg::DATA_W+FRAC_BITS-1:0] num_w;
   logic [nsr_pkg::DATA_W:0]             sum_w;
   logic [nsr_pkg::DATA_W-1:0]           delta_w;

   assign num_w   = {rad_ff, {FRAC_BITS{1'b0}}};
   assign sum_w   = (nsr_pkg::DATA_W+1)'(guess_ff) + (nsr_pkg::DATA_W+1)'(div_rsp.quotient);
   assign delta_w = (guess_ff > next_ff) ? guess_ff - next_ff : next_ff - guess_ff;

   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      guess_in     = guess_ff;
      next_in      = next_ff;
      iter_in      = iter_ff;
      limit_in     = limit_ff;
      root_in      = root_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;

      div_req.start    = 1'b0;
      div_req.rem_init = nsr_pkg::DATA_W'(num_w[nsr_pkg::DATA_W+FRAC_BITS-1:nsr_pkg::DATA_W]);
      div_req.low_init = num_w[nsr_pkg::DATA_W-1:0];
      div_req.divisor  = (guess_ff == '0) ? nsr_pkg::DATA_W'(1) : guess_ff;

      unique case (state_ff)
         nsr_pkg::NSR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rad_in   = req_radicand;
               iter_in  = '0;
               limit_in = 1'b0;
               if (req_radicand == '0) begin
                  guess_in = '0;
                  state_in = nsr_pkg::NSR_FINISH;
               end else begin
                  guess_in = GUESS_ONE;
                  state_in = nsr_pkg::NSR_START;
               end
            end
         end
         nsr_pkg::NSR_START: begin
            div_req.start = 1'b1;
            state_in      = nsr_pkg::NSR_WAIT;
         end
         nsr_pkg::NSR_WAIT: begin
            if (div_rsp.done) begin
               next_in  = sum_w[nsr_pkg::DATA_W:1];
               state_in = nsr_pkg::NSR_CHECK;
            end
         end
         nsr_pkg::NSR_CHECK: begin
            if (delta_w < nsr_pkg::DATA_W'(tolerance)) begin
               limit_in = 1'b0;
               state_in = nsr_pkg::NSR_FINISH;
            end else begin
               guess_in = next_ff;
               if (iter_ff == ITER_W'(MAX_ITER - 1)) begin
                  limit_in = 1'b1;
                  state_in = nsr_pkg::NSR_FINISH;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = nsr_pkg::NSR_START;
               end
            end
         end
         nsr_pkg::NSR_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               root_in      = (guess_ff > nsr_pkg::DATA_W'(nsr_pkg::ROOT_MAX))
                              ? nsr_pkg::ROOT_MAX : guess_ff[nsr_pkg::ROOT_W-1:0];
               hit_in       = limit_ff;
               state_in     = nsr_pkg::NSR_IDLE;
            end
         end
         default: state_in = nsr_pkg::NSR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsr_pkg::NSR_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         limit_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      guess_ff <= guess_in;
      next_ff  <= next_in;
      root_ff  <= root_in;
      hit_ff   <= hit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root      = root_ff;
   assign rsp_hit_limit = hit_ff;

endmodule

// ===== rtl/nsr_checker.sv =====
// Port-level checks for newton_square_root, attached by bind.
// Depends on newton_square_root_macros.svh and the top level's channels.
`include "newton_square_root_macros.svh"

module nsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_radicand,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_root,
   input logic        rsp_hit_limit
);

   `NSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root) && $stable(rsp_hit_limit), "result item changed while stalled")
   `NSR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input ready while an item is in work")
   `NSR_ASSERT_DLY2(a_zero_fast, clock, reset, req_valid && req_ready && req_radicand == 32'd0 && !rsp_valid, rsp_valid && rsp_root == 28'd0 && !rsp_hit_limit, "zero radicand not returned as zero")
   `NSR_ASSERT_NOW(a_limit_nonzero, clock, reset, rsp_valid && rsp_hit_limit, rsp_root != 28'd0, "capped result with zero root")

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_radicand  (req_ch.radicand),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_root      (rsp_ch.root),
   .rsp_hit_limit (rsp_ch.hit_limit)
);

// ===== verif/newton_square_root_checker.sv =====
// Checker for newton_square_root: watches the item, result and tolerance channels,
// predicts each root and compares it with what the block returns.
// Depends on nsr_pkg and the channel interfaces in nsr_if.
`timescale 1ns / 1ps

module newton_square_root_checker #(
   parameter int MAX_ITER  = 32,
   parameter int FRAC_BITS = 24
) (
   input  logic  clock,
   input  logic  reset,
   nsr_req_if    req_ch,
   nsr_rsp_if    rsp_ch,
   nsr_csr_if    csr_ch,
   output int    roots_outstanding,
   output int    mismatches
);

   typedef struct packed {
      logic [nsr_pkg::ROOT_W-1:0] root;
      logic                       hit_limit;
   } root_estimate_type;

   root_estimate_type            expected_roots[$];
   logic [nsr_pkg::TOL_W-1:0]    tolerance;

   function automatic root_estimate_type newton_root(input logic [nsr_pkg::DATA_W-1:0] x,
                                                     input logic [nsr_pkg::TOL_W-1:0] tol);
      root_estimate_type est;
      logic [63:0]    num;
      logic [63:0]    guess;
      logic [63:0]    quo;
      logic [63:0]    stepped;
      logic [63:0]    delta;
      int             n;
      est.root      = '0;
      est.hit_limit = 1'b0;
      if (x == '0) begin
         return est;
      end
      num   = {32'd0, x} << FRAC_BITS;
      guess = 64'd1 << FRAC_BITS;
      est.hit_limit = 1'b1;
      for (n = 0; n < MAX_ITER; n++) begin
         quo     = num / ((guess == 64'd0) ? 64'd1 : guess);
         stepped = (guess + quo) >> 1;
         delta   = (guess > stepped) ? guess - stepped : stepped - guess;
         if (delta < {39'd0, tol}) begin
            est.hit_limit = 1'b0;
            break;
         end
         guess = stepped;
      end
      // root field saturates once the estimate reaches 16.0
      if (guess > {36'd0, nsr_pkg::ROOT_MAX}) begin
         est.root = nsr_pkg::ROOT_MAX;
      end else begin
         est.root = guess[nsr_pkg::ROOT_W-1:0];
      end
      return est;
   endfunction

   initial begin
      roots_outstanding = 0;
      mismatches        = 0;
      tolerance         = nsr_pkg::TOL_RESET;
   end

   always @(posedge clock) begin
      root_estimate_type want;
      if (reset) begin
         tolerance = nsr_pkg::TOL_RESET;
         expected_roots.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            tolerance = csr_ch.tolerance;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_roots.push_back(newton_root(req_ch.radicand, tolerance));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_roots.size() == 0) begin
               $error("result item with no item waiting: root %h hit_limit %b",
                      rsp_ch.root, rsp_ch.hit_limit);
               mismatches = mismatches + 1;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_ch.root !== want.root) begin
                  $error("root: expected %h, actual %h", want.root, rsp_ch.root);
                  mismatches = mismatches + 1;
               end
               if (rsp_ch.hit_limit !== want.hit_limit) begin
                  $error("hit_limit: expected %b, actual %b", want.hit_limit,
                         rsp_ch.hit_limit);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      roots_outstanding = expected_roots.size();
   end

endmodule

// ===== verif/newton_square_root_tb.sv =====
// Top of the newton_square_root testbench: clock, reset, item and tolerance stimulus,
// random result stalls and the verdict.
// Depends on nsr_pkg, nsr_if, the block itself and newton_square_root_checker.
`timescale 1ns / 1ps

module newton_square_root_tb;

   localparam int MAX_ITER  = 32;
   localparam int FRAC_BITS = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   roots_outstanding;
   int   mismatches;

   nsr_req_if req_ch();
   nsr_rsp_if rsp_ch();
   nsr_csr_if csr_ch();

   newton_square_root #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   newton_square_root_checker #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch),
      .roots_outstanding (roots_outstanding),
      .mismatches        (mismatches)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [31:0] random_radicand();
      logic [15:0] r;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return 32'd0;
      end else if (pick <= 6) begin
         return $urandom;
      end else if (pick <= 10) begin
         return $urandom >> $urandom_range(1, 31);
      end else if (pick <= 13) begin
         return 32'hFFFF_FFFF - $urandom_range(0, 65535);
      end else if (pick <= 17) begin
         // exact squares of Q4.12 values
         r = 16'($urandom_range(1, 65535));
         return {16'd0, r} * {16'd0, r};
      end
      return 32'h0100_0000 + $urandom_range(0, 511) - 256;
   endfunction

   // valid stays high across back-to-back items
   task automatic send_radicand(input logic [31:0] value);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 8) ? $urandom_range(1, 60) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.radicand <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_radicand(random_radicand());
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (roots_outstanding == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [24:0] value);
      drain();
      csr_ch.valid     <= 1'b1;
      csr_ch.tolerance <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] directed[$];
      req_ch.valid     = 1'b0;
      req_ch.radicand  = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.tolerance = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset tolerance; zero, tiny, 1.0, and saturating radicands
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h00FF_FFFF,
                   32'h0100_0000, 32'h0100_0001, 32'h0200_0000, 32'h0400_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'hFF00_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (directed[k]) send_radicand(directed[k]);
      send_random(60);

      // zero tolerance runs every nonzero item to the cap
      set_tolerance(25'd0);
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0100_0000, 32'h0900_0000,
                   32'hFFFF_FFFF};
      foreach (directed[k]) send_radicand(directed[k]);
      send_random(10);

      set_tolerance(25'h100_0000);
      directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
      foreach (directed[k]) send_radicand(directed[k]);
      send_random(50);

      steady = 1'b1;
      set_tolerance(25'd1);
      send_random(80);
      steady = 1'b0;

      set_tolerance(25'h0FF_FFFF);
      send_random(50);

      repeat (4) begin
         set_tolerance(25'($urandom_range(0, 25'h100_0000) >> $urandom_range(0, 24)));
         send_random(70);
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== newton_square_root.f =====
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_if.sv
rtl/nsr_divider.sv
rtl/nsr_newton_ctrl.sv
rtl/newton_square_root.sv
rtl/nsr_checker.sv
verif/newton_square_root_checker.sv
verif/newton_square_root_tb.sv
